// File: rtl/lpwe_pkg.sv
// Package for the LED pulse-width bit encoder.
// Holds the timing register struct, result struct, register indexes and count helper.
// No dependencies.
package lpwe_pkg;

    localparam int unsigned TICK_W     = 8;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned BITS_CNT_W = 4;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [BITS_CNT_W-1:0] BITS_PER_BYTE = BITS_CNT_W'(BYTE_W);

    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 2'd3;

    localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 8'd26;
    localparam logic [TICK_W-1:0] ONE_LOW_RST   = 8'd14;
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 8'd13;
    localparam logic [TICK_W-1:0] ZERO_LOW_RST  = 8'd27;

    typedef struct packed {
        logic [TICK_W-1:0] one_high_ticks;
        logic [TICK_W-1:0] one_low_ticks;
        logic [TICK_W-1:0] zero_high_ticks;
        logic [TICK_W-1:0] zero_low_ticks;
    } timing_t;

    typedef struct packed {
        logic line_level;
        logic byte_taken;
        logic idle;
    } result_t;

    // Phase length for the given bit; a zero count runs as one tick.
    function automatic logic [TICK_W-1:0] phase_len(
        input logic              bit_val,
        input logic [TICK_W-1:0] one_ticks,
        input logic [TICK_W-1:0] zero_ticks
    );
        logic [TICK_W-1:0] sel;
        sel = bit_val ? one_ticks : zero_ticks;
        return (sel == '0) ? TICK_W'(1) : sel;
    endfunction

endpackage

// File: rtl/lpwe_cfg_regs.sv
// Timing register file of the LED pulse-width bit encoder.
// Uses lpwe_pkg for the register indexes, reset values and timing_t.
module lpwe_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [lpwe_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [lpwe_pkg::TICK_W-1:0]     wr_data,
    output lpwe_pkg::timing_t               timing
);

    lpwe_pkg::timing_t timing_reg;
    lpwe_pkg::timing_t timing_next;

    always_comb begin
        timing_next = timing_reg;
        if (wr_en) begin
            case (wr_index)
                lpwe_pkg::REG_ONE_HIGH:  timing_next.one_high_ticks  = wr_data;
                lpwe_pkg::REG_ONE_LOW:   timing_next.one_low_ticks   = wr_data;
                lpwe_pkg::REG_ZERO_HIGH: timing_next.zero_high_ticks = wr_data;
                lpwe_pkg::REG_ZERO_LOW:  timing_next.zero_low_ticks  = wr_data;
                default:                 timing_next = timing_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.one_high_ticks  <= lpwe_pkg::ONE_HIGH_RST;
            timing_reg.one_low_ticks   <= lpwe_pkg::ONE_LOW_RST;
            timing_reg.zero_high_ticks <= lpwe_pkg::ZERO_HIGH_RST;
            timing_reg.zero_low_ticks  <= lpwe_pkg::ZERO_LOW_RST;
        end else begin
            timing_reg <= timing_next;
        end
    end

    assign timing = timing_reg;

endmodule

// File: rtl/lpwe_engine.sv
// Bit timing engine: shift register, bit counter and phase counter, one tick per step.
// Uses lpwe_pkg for timing_t, result_t and phase_len.
module lpwe_engine (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic                         byte_offered,
    input  logic [lpwe_pkg::BYTE_W-1:0]  byte_value,
    input  lpwe_pkg::timing_t            timing,
    output lpwe_pkg::result_t            result
);

    logic [lpwe_pkg::BYTE_W-1:0]     shift_bits_reg, shift_bits_next;
    logic [lpwe_pkg::BITS_CNT_W-1:0] bits_left_reg, bits_left_next;
    logic                            low_phase_reg, low_phase_next;
    logic [lpwe_pkg::TICK_W-1:0]     ticks_left_reg, ticks_left_next;
    logic                            sending_reg, sending_next;
    logic [lpwe_pkg::BYTE_W-1:0]     shifted;
    logic                            free_now;

    always_comb begin
        shift_bits_next = shift_bits_reg;
        bits_left_next  = bits_left_reg;
        low_phase_next  = low_phase_reg;
        ticks_left_next = ticks_left_reg;
        sending_next    = sending_reg;
        shifted         = {shift_bits_reg[lpwe_pkg::BYTE_W-2:0], 1'b0};
        free_now        = !sending_reg;
        result.line_level = sending_reg && !low_phase_reg;
        result.idle       = !sending_reg;
        result.byte_taken = 1'b0;

        if (sending_reg) begin
            if (ticks_left_reg > lpwe_pkg::TICK_W'(1)) begin
                ticks_left_next = ticks_left_reg - lpwe_pkg::TICK_W'(1);
            end else if (!low_phase_reg) begin
                low_phase_next  = 1'b1;
                ticks_left_next = lpwe_pkg::phase_len(shift_bits_reg[lpwe_pkg::BYTE_W-1],
                    timing.one_low_ticks, timing.zero_low_ticks);
            end else begin
                shift_bits_next = shifted;
                bits_left_next  = (bits_left_reg != '0) ?
                                  bits_left_reg - lpwe_pkg::BITS_CNT_W'(1) : '0;
                if (bits_left_next != '0) begin
                    low_phase_next  = 1'b0;
                    ticks_left_next = lpwe_pkg::phase_len(shifted[lpwe_pkg::BYTE_W-1],
                        timing.one_high_ticks, timing.zero_high_ticks);
                end else begin
                    free_now = 1'b1;
                end
            end
        end

        if (free_now) begin
            if (byte_offered) begin
                shift_bits_next   = byte_value;
                bits_left_next    = lpwe_pkg::BITS_PER_BYTE;
                low_phase_next    = 1'b0;
                ticks_left_next   = lpwe_pkg::phase_len(byte_value[lpwe_pkg::BYTE_W-1],
                    timing.one_high_ticks, timing.zero_high_ticks);
                sending_next      = 1'b1;
                result.byte_taken = 1'b1;
            end else begin
                sending_next    = 1'b0;
                low_phase_next  = 1'b0;
                ticks_left_next = '0;
                bits_left_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_bits_reg <= '0;
            bits_left_reg  <= '0;
            low_phase_reg  <= 1'b0;
            ticks_left_reg <= '0;
            sending_reg    <= 1'b0;
        end else if (step) begin
            shift_bits_reg <= shift_bits_next;
            bits_left_reg  <= bits_left_next;
            low_phase_reg  <= low_phase_next;
            ticks_left_reg <= ticks_left_next;
            sending_reg    <= sending_next;
        end
    end

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !sending_reg |-> (bits_left_reg == '0 && !low_phase_reg && ticks_left_reg == '0))
        else $error("idle engine holds stale bit or phase state");

    a_busy_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        sending_reg |-> (bits_left_reg != '0 && ticks_left_reg != '0))
        else $error("sending with empty bit or tick count");

    a_bits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_left_reg <= lpwe_pkg::BITS_PER_BYTE)
        else $error("bit counter above byte width");

    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && result.byte_taken) |=>
            (sending_reg && !low_phase_reg && bits_left_reg == lpwe_pkg::BITS_PER_BYTE))
        else $error("taken byte did not start its first high pulse");

endmodule

// File: rtl/led_pulse_width_bit_encoder_core.sv
// Top level of the LED pulse-width bit encoder: ports, output register, config port.
// Uses lpwe_pkg, lpwe_cfg_regs and lpwe_engine.
//
//  channel | ports                                  | direction
//  s_      | s_valid s_ready s_byte_offered s_byte_value | tick in
//  m_      | m_valid m_ready m_line_level m_byte_taken m_idle | tick result out
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data | timing register write
//
// One tick transfer per cycle; its result is in the output register the next cycle.
// The engine state steps once per input transfer, so the rate is set by that one register stage.
// Input stalls only while the output register is full and m_ready is low.
// Config writes are always taken (cfg_ready high out of reset).
// Synchronous active-low reset clears engine state and output valid, presets timing registers.
module led_pulse_width_bit_encoder_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_byte_offered,
    input  logic [lpwe_pkg::BYTE_W-1:0]     s_byte_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_line_level,
    output logic                            m_byte_taken,
    output logic                            m_idle,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lpwe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpwe_pkg::TICK_W-1:0]     cfg_data
);

    lpwe_pkg::timing_t timing;
    lpwe_pkg::result_t result;
    lpwe_pkg::result_t result_reg;
    logic              m_valid_reg;
    logic              s_xfer;

    assign cfg_ready = aresetn;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_xfer    = s_valid && s_ready;

    lpwe_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .timing   (timing)
    );

    lpwe_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (s_xfer),
        .byte_offered (s_byte_offered),
        .byte_value   (s_byte_value),
        .timing       (timing),
        .result       (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            result_reg <= result;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_line_level = result_reg.line_level;
    assign m_byte_taken = result_reg.byte_taken;
    assign m_idle       = result_reg.idle;

endmodule
